### rtl/stack_with_auxiliary_stack_sort_assert.svh
// Assertion macros shared by the stack-sort RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef STACK_WITH_AUXILIARY_STACK_SORT_ASSERT_SVH
`define STACK_WITH_AUXILIARY_STACK_SORT_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SWS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define SWS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sws_pkg.sv
// Shared types and constants for the stack with auxiliary-stack sort.
// No dependencies; imported by every module of the block except sws_ram.
package sws_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 64;

	// Request operation codes
	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2,
		OP_SORT = 2'd3
	} op_t;

	// Response status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                      operation;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		status_t                  status;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    main_we;       // write main stack at its count
		logic    main_wsel_aux; // main write data from aux read data, else request value
		logic    main_inc;
		logic    main_dec;
		logic    main_rd;       // read main top (count - 1)
		logic    aux_we;        // write item onto aux stack
		logic    aux_inc;
		logic    aux_dec;
		logic    aux_rd;
		logic    aux_rd_below;  // read aux at count - 2 instead of count - 1
		logic    item_load;     // capture main read data as the sort item
		logic    item_sel_q;    // compare with held item, else main read data
		logic    res_load;
		logic    res_from_ram;  // result value from main read data, else zero
		status_t res_status;
		logic    out_load;      // hand pending result to the output register
	} sws_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic main_empty;
		logic main_full;
		logic aux_empty;
		logic aux_last;
		logic item_lt;
		logic out_free;
	} sws_sts_t;

endpackage

### rtl/sws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds its data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/sws_dp.sv
// Datapath: main and aux stack memories, counts, sort item, result and output registers.
// Depends on sws_pkg, sws_ram and the assertion macro header.
`include "stack_with_auxiliary_stack_sort_assert.svh"

module sws_dp import sws_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  sws_cmd_t cmd,
	output sws_sts_t sts,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output rsp_t     rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic [CW-1:0] main_cnt_q;
	logic [CW-1:0] aux_cnt_q;
	logic [CW-1:0] main_top_idx;
	logic [CW-1:0] aux_rd_idx;
	logic [DATA_W-1:0] main_rdata;
	logic [DATA_W-1:0] aux_rdata;
	logic [DATA_W-1:0] main_wdata;
	logic signed [DATA_W-1:0] item_q;
	logic signed [DATA_W-1:0] item;
	logic signed [DATA_W-1:0] res_top_q;
	status_t res_status_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	// Address generation
	assign main_top_idx = main_cnt_q - CW'(1);
	assign aux_rd_idx   = cmd.aux_rd_below ? aux_cnt_q - CW'(2) : aux_cnt_q - CW'(1);
	assign main_wdata   = cmd.main_wsel_aux ? aux_rdata : req.value;

	// Item under insertion: fresh from the main stack or held
	assign item = cmd.item_sel_q ? item_q : $signed(main_rdata);

	sws_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_main_ram (
		.clk   (clk),
		.we    (cmd.main_we),
		.waddr (main_cnt_q[AW-1:0]),
		.wdata (main_wdata),
		.re    (cmd.main_rd),
		.raddr (main_top_idx[AW-1:0]),
		.rdata (main_rdata)
	);

	sws_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_aux_ram (
		.clk   (clk),
		.we    (cmd.aux_we),
		.waddr (aux_cnt_q[AW-1:0]),
		.wdata (item),
		.re    (cmd.aux_rd),
		.raddr (aux_rd_idx[AW-1:0]),
		.rdata (aux_rdata)
	);

	// Stack counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_cnt_q <= '0;
			aux_cnt_q  <= '0;
		end else begin
			if (cmd.main_inc) begin
				main_cnt_q <= main_cnt_q + CW'(1);
			end else if (cmd.main_dec) begin
				main_cnt_q <= main_cnt_q - CW'(1);
			end
			if (cmd.aux_inc) begin
				aux_cnt_q <= aux_cnt_q + CW'(1);
			end else if (cmd.aux_dec) begin
				aux_cnt_q <= aux_cnt_q - CW'(1);
			end
		end
	end

	// Sort item and pending result
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			item_q <= $signed(main_rdata);
		end
		if (cmd.res_load) begin
			res_top_q    <= cmd.res_from_ram ? $signed(main_rdata) : '0;
			res_status_q <= cmd.res_status;
		end
		if (cmd.out_load) begin
			rsp_q.top_value <= res_top_q;
			rsp_q.status    <= res_status_q;
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status to the controller
	assign sts.main_empty = (main_cnt_q == '0);
	assign sts.main_full  = (main_cnt_q == CW'(DEPTH));
	assign sts.aux_empty  = (aux_cnt_q == '0);
	assign sts.aux_last   = (aux_cnt_q == CW'(1));
	assign sts.item_lt    = (item < $signed(aux_rdata));
	assign sts.out_free   = !rsp_valid_q || rsp_ready;

	`SWS_ASSERT_IMP(a_main_bound, 1'b1, main_cnt_q <= CW'(DEPTH), "main count beyond depth")
	`SWS_ASSERT_IMP(a_total_bound, 1'b1, ({1'b0, main_cnt_q} + {1'b0, aux_cnt_q}) <= (CW+1)'(DEPTH), "stacks hold more than depth")
	`SWS_ASSERT_NXT(a_out_load, cmd.out_load, rsp_valid_q, "loaded result not presented")

endmodule

### rtl/sws_ctrl.sv
// Controller: sequences push, pop, peek and the auxiliary-stack sort.
// Depends on sws_pkg and the assertion macro header.
`include "stack_with_auxiliary_stack_sort_assert.svh"

module sws_ctrl import sws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  op_t      operation,
	input  sws_sts_t sts,
	output sws_cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE,
		RD,
		RESP,
		S_POP,
		S_ITEM,
		S_CMP,
		S_BACK
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					case (operation)
						OP_PUSH: begin
							cmd.res_load = 1'b1;
							if (sts.main_full) begin
								cmd.res_status = ST_FULL;
							end else begin
								cmd.res_status = ST_OK;
								cmd.main_we    = 1'b1;
								cmd.main_inc   = 1'b1;
							end
							state_d = RESP;
						end
						OP_POP, OP_PEEK: begin
							if (sts.main_empty) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = ST_EMPTY;
								state_d        = RESP;
							end else begin
								cmd.main_rd  = 1'b1;
								cmd.main_dec = (operation == OP_POP);
								state_d      = RD;
							end
						end
						OP_SORT: begin
							state_d = S_POP;
						end
						default: begin
							state_d = IDLE;
						end
					endcase
				end
			end
			RD: begin
				cmd.res_load     = 1'b1;
				cmd.res_from_ram = 1'b1;
				cmd.res_status   = ST_OK;
				state_d          = RESP;
			end
			RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = IDLE;
				end
			end
			// take the next item off the main stack, start the return, or finish when both stacks are empty
			S_POP: begin
				if (!sts.main_empty) begin
					cmd.main_rd  = 1'b1;
					cmd.main_dec = 1'b1;
					cmd.aux_rd   = 1'b1;
					state_d      = S_ITEM;
				end else if (!sts.aux_empty) begin
					cmd.aux_rd = 1'b1;
					state_d    = S_BACK;
				end else begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = RESP;
				end
			end
			// larger aux tops go back to main, else the item lands on aux
			S_ITEM, S_CMP: begin
				cmd.item_load  = (state_q == S_ITEM);
				cmd.item_sel_q = (state_q == S_CMP);
				if (!sts.aux_empty && sts.item_lt) begin
					cmd.main_we       = 1'b1;
					cmd.main_wsel_aux = 1'b1;
					cmd.main_inc      = 1'b1;
					cmd.aux_dec       = 1'b1;
					cmd.aux_rd        = 1'b1;
					cmd.aux_rd_below  = 1'b1;
					state_d           = S_CMP;
				end else begin
					cmd.aux_we  = 1'b1;
					cmd.aux_inc = 1'b1;
					state_d     = S_POP;
				end
			end
			// move the whole aux stack back onto main
			S_BACK: begin
				cmd.main_we       = 1'b1;
				cmd.main_wsel_aux = 1'b1;
				cmd.main_inc      = 1'b1;
				cmd.aux_dec       = 1'b1;
				if (sts.aux_last) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = RESP;
				end else begin
					cmd.aux_rd       = 1'b1;
					cmd.aux_rd_below = 1'b1;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SWS_ASSERT_IMP(a_aux_idle_empty, state_q == IDLE, sts.aux_empty, "aux stack not empty when idle")
	`SWS_ASSERT_IMP(a_out_free, cmd.out_load, sts.out_free, "output overwritten before taken")
	`SWS_ASSERT_IMP(a_no_full_push, cmd.main_we && !cmd.main_wsel_aux, !sts.main_full, "push written onto full stack")

endmodule

### rtl/stack_with_auxiliary_stack_sort.sv
// Bounded LIFO of signed 32-bit values with push, pop, peek and an in-place sort that
// leaves the smallest value on top. Each request gives exactly one response beat. A pop
// or peek reads the top through one registered memory read before its response. A sort
// may move elements back from the auxiliary stack onto the main stack during insertion
// (at most n(n-1)/2 for n items). Every original item is popped, compared and finally
// returned, and every element moved back is popped and compared again; each stack
// memory has one registered read port. The request is held off while an operation
// runs; a finished response waits in an output register, and the next request is taken
// while it waits. Depth comes from DEPTH.
// Depends on sws_pkg, sws_ctrl and sws_dp.
module stack_with_auxiliary_stack_sort import sws_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	sws_cmd_t cmd;
	sws_sts_t sts;

	sws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.operation (req.operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	sws_dp #(.DEPTH(DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
